>>> sv/mouse_look_camera_orientation_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mouse-look camera block
// Shared concurrent assertion forms used by the RTL.
// ----------------------------------------------------------------------------
`ifndef MOUSE_LOOK_CAMERA_ORIENTATION_DEFINES_SVH
`define MOUSE_LOOK_CAMERA_ORIENTATION_DEFINES_SVH

// implication checked every clock, off during reset
`define MLC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mlc_pkg.sv
// ----------------------------------------------------------------------------
// mlc_pkg
// Types and constants for the mouse-look camera orientation block.
// ----------------------------------------------------------------------------
`default_nettype none
package mlc_pkg;
    localparam int CordicSteps = 16;
    localparam logic signed [33:0] PitchLimit  = 34'sd5832704;
    localparam logic signed [33:0] YawTurn     = 34'sd23592960;
    localparam logic signed [33:0] HalfTurn    = 34'sd11796480;
    localparam logic signed [33:0] QuarterTurn = 34'sd5898240;
    localparam logic signed [33:0] CordicStart = 34'sd652032874;

    localparam logic [1:0] RegDist = 2'd0;
    localparam logic [1:0] RegPosX = 2'd1;
    localparam logic [1:0] RegPosY = 2'd2;
    localparam logic [1:0] RegPosZ = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ANGLE, ST_YAWFOLD, ST_CORDIC, ST_CORDIC_DONE,
        ST_MUL_LX, ST_MUL_LZ, ST_MUL_OX, ST_MUL_OY, ST_MUL_OZ, ST_TARGET, ST_OUT
    } state_t;

    // cordic job control
    typedef struct packed {
        logic start;
        logic signed [33:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic done;
        logic signed [15:0] cos_q14;
        logic signed [15:0] sin_q14;
    } cordic_rsp_t;

    function automatic logic signed [33:0] atan_deg(input logic [3:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                4'd0: r = 34'sd2949120;   4'd1: r = 34'sd1740967;
                4'd2: r = 34'sd919879;    4'd3: r = 34'sd466945;
                4'd4: r = 34'sd234379;    4'd5: r = 34'sd117304;
                4'd6: r = 34'sd58666;     4'd7: r = 34'sd29335;
                4'd8: r = 34'sd14668;     4'd9: r = 34'sd7334;
                4'd10: r = 34'sd3667;     4'd11: r = 34'sd1833;
                4'd12: r = 34'sd917;      4'd13: r = 34'sd458;
                4'd14: r = 34'sd229;      4'd15: r = 34'sd115;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

    // round half up of Q.30 to Q1.14, clamp to unit
    function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + 34'sd32768) >>> 16;
            if (r > 34'sd16384) r = 34'sd16384;
            else if (r < -34'sd16384) r = -34'sd16384;
            return r[15:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> sv/mlc_cordic.sv
// ----------------------------------------------------------------------------
// mlc_cordic
// Iterative rotation CORDIC, one micro-rotation per cycle, degree angles.
// ----------------------------------------------------------------------------
`default_nettype none
module mlc_cordic (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mlc_pkg::cordic_req_t req,
    output mlc_pkg::cordic_rsp_t     rsp
);
    import mlc_pkg::*;

    logic signed [33:0] x_reg, y_reg, z_reg;
    logic signed [33:0] x_next, y_next, z_next;
    logic [3:0] step_reg;
    logic busy_reg, done_reg;

    // one micro-rotation
    always_comb
    begin
        if (!z_reg[33])
        begin
            x_next = x_reg - (y_reg >>> step_reg);
            y_next = y_reg + (x_reg >>> step_reg);
            z_next = z_reg - atan_deg(step_reg);
        end
        else
        begin
            x_next = x_reg + (y_reg >>> step_reg);
            y_next = y_reg - (x_reg >>> step_reg);
            z_next = z_reg + atan_deg(step_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 4'd1;
                if (step_reg == 4'(CordicSteps - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= CordicStart;
            y_reg <= '0;
            z_reg <= req.angle;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_q14 = to_q14(x_reg);
    assign rsp.sin_q14 = to_q14(y_reg);
endmodule
`default_nettype wire

>>> sv/mouse_look_camera_orientation.sv
// ----------------------------------------------------------------------------
// mouse_look_camera_orientation
// Mouse-delta driven yaw/pitch camera with CORDIC look and strafe vectors.
// ----------------------------------------------------------------------------
// One request in, one result out. A request is stepped into the angles, then
// run through two passes of the 16-step CORDIC unit (pitch, then yaw). Each
// pass runs 16 micro-rotations and is followed by a step to latch and fold.
// The five products then go through the single shared 21x16 multiplier, the
// target sum is formed and the output register is loaded. While m_tready is
// low with a result held, the block waits in its last step. A new request is
// taken only once the previous result has moved into the output register.
`default_nettype none
module mouse_look_camera_orientation (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // delta_x[15:0], delta_y[31:16]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [223:0]      m_tdata,   // look_x,y,z (16 each), orient_x,y,z,
                                         // target_x,y,z (24 each), strafe_x,z
                                         // (16 each)
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import mlc_pkg::*;
    `include "mouse_look_camera_orientation_defines.svh"

    state_t state_reg, state_next;
    logic [19:0] dist_reg;
    logic signed [23:0] posx_reg, posy_reg, posz_reg;
    logic signed [33:0] pitch_reg, yaw_reg, angle_reg;
    logic flip_reg, second_reg;
    logic signed [15:0] dx_reg, dy_reg;
    logic signed [15:0] cp_reg, sp_reg, ct_reg, st_reg, lx_reg, lz_reg;
    logic signed [23:0] ox_reg, oy_reg, oz_reg;
    logic signed [23:0] tx_reg, ty_reg, tz_reg;
    logic out_valid_reg;
    logic [223:0] out_reg;

    cordic_req_t creq;
    cordic_rsp_t crsp;

    mlc_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

    // angle steps; a yaw step can exceed one full turn either way
    logic signed [33:0] stepx, stepy, p_sum, p_clamp, y_sum, y_mod, a_wrap;
    always_comb
    begin
        stepx = (-(34'(dx_reg) * 34'sd19661) + 34'sd8) >>> 4;
        stepy = (-(34'(dy_reg) * 34'sd19661) + 34'sd8) >>> 4;
        p_sum = pitch_reg + stepy;
        if (p_sum > PitchLimit) p_clamp = PitchLimit;
        else if (p_sum < -PitchLimit) p_clamp = -PitchLimit;
        else p_clamp = p_sum;
        y_sum = yaw_reg + stepx;
        if (y_sum >= YawTurn + YawTurn) y_mod = y_sum - YawTurn - YawTurn;
        else if (y_sum >= YawTurn) y_mod = y_sum - YawTurn;
        else if (y_sum < -YawTurn) y_mod = y_sum + YawTurn + YawTurn;
        else if (y_sum < 0) y_mod = y_sum + YawTurn;
        else y_mod = y_sum;
        a_wrap = (yaw_reg > HalfTurn) ? yaw_reg - YawTurn : yaw_reg;
    end

    // shared multiplier with Q14 rounding
    logic signed [20:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [36:0] mul_p;
    logic signed [36:0] mul_r;
    always_comb
    begin
        case (state_reg)
            ST_MUL_LX: begin mul_a = 21'(cp_reg); mul_b = st_reg; end
            ST_MUL_LZ: begin mul_a = 21'(cp_reg); mul_b = ct_reg; end
            ST_MUL_OX: begin mul_a = $signed({1'b0, dist_reg}); mul_b = lx_reg; end
            ST_MUL_OY: begin mul_a = $signed({1'b0, dist_reg}); mul_b = -sp_reg; end
            ST_MUL_OZ: begin mul_a = $signed({1'b0, dist_reg}); mul_b = lz_reg; end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
        mul_r = (mul_p + 37'sd8192) >>> 14;
    end

    function automatic logic signed [23:0] sat24(input logic signed [24:0] v);
        begin
            if (v > 25'sd8388607) return 24'sh7fffff;
            else if (v < -25'sd8388608) return 24'sh800000;
            else return v[23:0];
        end
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_tvalid && s_tready) state_next = ST_ANGLE;
            ST_ANGLE:       state_next = ST_CORDIC;
            ST_YAWFOLD:     state_next = ST_CORDIC;
            ST_CORDIC:      if (crsp.done) state_next = ST_CORDIC_DONE;
            ST_CORDIC_DONE: state_next = second_reg ? ST_MUL_LX : ST_YAWFOLD;
            ST_MUL_LX:      state_next = ST_MUL_LZ;
            ST_MUL_LZ:      state_next = ST_MUL_OX;
            ST_MUL_OX:      state_next = ST_MUL_OY;
            ST_MUL_OY:      state_next = ST_MUL_OZ;
            ST_MUL_OZ:      state_next = ST_TARGET;
            ST_TARGET:      state_next = ST_OUT;
            ST_OUT:         if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer; the pitch pass starts on the stepped angle
    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        creq.start = (state_reg == ST_ANGLE) || (state_reg == ST_YAWFOLD);
        creq.angle = (state_reg == ST_ANGLE) ? p_clamp : angle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dist_reg      <= 20'd2560;
            posx_reg      <= '0;
            posy_reg      <= '0;
            posz_reg      <= '0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    RegDist: dist_reg <= cfg_data[19:0];
                    RegPosX: posx_reg <= cfg_data;
                    RegPosY: posy_reg <= cfg_data;
                    RegPosZ: posz_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_ANGLE)
            begin
                pitch_reg <= p_clamp;
                yaw_reg <= y_mod;
            end
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready)) out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dx_reg <= s_tdata[15:0];
                dy_reg <= s_tdata[31:16];
                second_reg <= 1'b0;
            end
            ST_YAWFOLD:
            begin
                second_reg <= 1'b1;
            end
            ST_CORDIC_DONE:
            begin
                if (!second_reg)
                begin
                    cp_reg <= crsp.cos_q14;
                    sp_reg <= crsp.sin_q14;
                    if (a_wrap > QuarterTurn)
                    begin
                        angle_reg <= a_wrap - HalfTurn; flip_reg <= 1'b1;
                    end
                    else if (a_wrap < -QuarterTurn)
                    begin
                        angle_reg <= a_wrap + HalfTurn; flip_reg <= 1'b1;
                    end
                    else
                    begin
                        angle_reg <= a_wrap; flip_reg <= 1'b0;
                    end
                end
                else
                begin
                    ct_reg <= flip_reg ? -crsp.cos_q14 : crsp.cos_q14;
                    st_reg <= flip_reg ? -crsp.sin_q14 : crsp.sin_q14;
                end
            end
            ST_MUL_LX: lx_reg <= -mul_r[15:0];
            ST_MUL_LZ: lz_reg <= mul_r[15:0];
            ST_MUL_OX: ox_reg <= mul_r[23:0];
            ST_MUL_OY: oy_reg <= mul_r[23:0];
            ST_MUL_OZ: oz_reg <= mul_r[23:0];
            ST_TARGET:
            begin
                tx_reg <= sat24(25'(posx_reg) + 25'(ox_reg));
                ty_reg <= sat24(25'(posy_reg) + 25'(oy_reg));
                tz_reg <= sat24(25'(posz_reg) + 25'(oz_reg));
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                    out_reg <= {st_reg, ct_reg, tz_reg, ty_reg, tx_reg,
                                oz_reg, oy_reg, ox_reg, lz_reg, -sp_reg, lx_reg};
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    `MLC_ASSERT_IMP(a_pitch_range, 1'b1, (pitch_reg <= PitchLimit) && (pitch_reg >= -PitchLimit), "pitch out of range")
    `MLC_ASSERT_IMP(a_yaw_range, 1'b1, (yaw_reg >= 0) && (yaw_reg < YawTurn), "yaw out of range")
    `MLC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
endmodule
`default_nettype wire
